/* hdl/running_average_background_subtract_top_assert.svh */
// Assertion shorthands; expect clk and arst_n in scope.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_TOP_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_TOP_ASSERT_SVH

// same-cycle implication
`define RABS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RABS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rabs_pkg.sv */
package rabs_pkg;

	localparam int ADDR_W      = 19;
	localparam int CHAN_W      = 8;
	localparam int NUM_LANES   = 3;
	localparam int ENTRY_W     = NUM_LANES * CHAN_W;
	localparam int XADDR_W     = 24;  // holds any legal frame size

	localparam int FRAME_PIXELS_DEF         = 524288;
	localparam int WEIGHT_FRACTION_BITS_DEF = 8;

	localparam int THRESH_W     = 8;
	localparam int WEIGHT_W     = 9;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 9;

	localparam logic [THRESH_W-1:0] DIFF_THRESHOLD_RST = 8'd30;
	localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST   = 9'd13;

	// BT.601 luma in Q0.14
	localparam int GRAY_SUM_W = 22;
	localparam int GRAY_SHIFT = 14;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KR   = 22'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KG   = 22'd9617;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KB   = 22'd1868;
	localparam logic [GRAY_SUM_W-1:0] GRAY_HALF = 22'd8192;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DIFF_THRESHOLD   = 2'd0,
		CFG_BLEND_WEIGHT     = 2'd1,
		CFG_SELECTIVE_UPDATE = 2'd2,
		CFG_COLOUR_MODE      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_INIT    = 1'b0,
		REQ_PROCESS = 1'b1
	} req_t;

	typedef struct packed {
		logic                colour;
		logic [THRESH_W-1:0] threshold;
		logic [WEIGHT_W-1:0] weight;
	} upd_ctrl_t;

endpackage

/* hdl/rabs_if.sv */
interface rabs_pix_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [rabs_pkg::ADDR_W-1:0] pixel_address;
	logic [rabs_pkg::CHAN_W-1:0] red;
	logic [rabs_pkg::CHAN_W-1:0] green;
	logic [rabs_pkg::CHAN_W-1:0] blue;

	modport source (output valid, req_type, pixel_address, red, green, blue, input ready);
	modport sink   (input valid, req_type, pixel_address, red, green, blue, output ready);
endinterface

interface rabs_mask_if;
	logic                        valid;
	logic                        ready;
	logic                        foreground;
	logic [rabs_pkg::ADDR_W-1:0] out_address;

	modport source (output valid, foreground, out_address, input ready);
	modport sink   (input valid, foreground, out_address, output ready);
endinterface

/* hdl/rabs_store.sv */
module rabs_store #(
	parameter int DEPTH = rabs_pkg::FRAME_PIXELS_DEF,
	parameter int IDX_W = 19
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_idx,
	output logic [rabs_pkg::ENTRY_W-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [rabs_pkg::ENTRY_W-1:0] wr_data
);

	logic [rabs_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// read-before-write on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

/* hdl/rabs_update.sv */
module rabs_update #(
	parameter int WEIGHT_FRACTION_BITS = rabs_pkg::WEIGHT_FRACTION_BITS_DEF
) (
	input  rabs_pkg::upd_ctrl_t          ctrl,
	input  logic [rabs_pkg::ENTRY_W-1:0] pix,
	input  logic [rabs_pkg::ENTRY_W-1:0] bg,
	output logic                         fg,
	output logic [rabs_pkg::ENTRY_W-1:0] new_word
);

	localparam int F     = WEIGHT_FRACTION_BITS;
	localparam int W_W   = F + 1;
	localparam int CMP_W = (W_W > rabs_pkg::WEIGHT_W) ? W_W : rabs_pkg::WEIGHT_W;
	localparam int ACC_W = F + rabs_pkg::CHAN_W + 1;
	localparam int CW    = rabs_pkg::CHAN_W;
	localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << F;
	localparam logic [W_W-1:0]   ONE_W   = W_W'(1) << F;
	localparam logic [ACC_W-1:0] HALF    = ACC_W'(ONE_W >> 1);

	logic [CMP_W-1:0] wt_ext;
	logic [W_W-1:0]   w;
	logic [W_W-1:0]   w_inv;

	logic [rabs_pkg::NUM_LANES-1:0]         lane_fg;
	logic [rabs_pkg::NUM_LANES-1:0][CW-1:0] lane_new;

	// alpha above one saturates to one
	assign wt_ext = CMP_W'(ctrl.weight);
	assign w      = (wt_ext > ONE_CMP) ? ONE_W : W_W'(wt_ext);
	assign w_inv  = ONE_W - w;

	for (genvar l = 0; l < rabs_pkg::NUM_LANES; l++) begin : g_lane
		logic [CW-1:0]    p;
		logic [CW-1:0]    b;
		logic [CW-1:0]    diff;
		logic [ACC_W-1:0] acc;

		assign p    = pix[l*CW +: CW];
		assign b    = bg[l*CW +: CW];
		assign diff = (p > b) ? (p - b) : (b - p);
		assign lane_fg[l] = diff > ctrl.threshold;
		assign acc  = ACC_W'(w) * ACC_W'(p) + ACC_W'(w_inv) * ACC_W'(b) + HALF;
		assign lane_new[l] = acc[F +: CW];
	end

	// lane 0 carries gray in gray mode
	assign fg       = ctrl.colour ? (|lane_fg) : lane_fg[0];
	assign new_word = ctrl.colour ? rabs_pkg::ENTRY_W'(lane_new)
	                              : rabs_pkg::ENTRY_W'(lane_new[0]);

endmodule

/* hdl/running_average_background_subtract_top.sv */
// Running-average background subtraction, one pixel per clock while mask does not stall.
//  pixel (rabs_pix_if sink): req_type REQ_INIT loads the frame store entry at
//    pixel_address (RGB in colour mode, BT.601 gray otherwise); REQ_PROCESS
//    compares the pixel with the stored background and blends it in.
//  mask (rabs_mask_if source): one transaction per process item carrying the
//    foreground flag and its address; init items give none.
//  cfg_we / cfg_index / cfg_wdata: register writes, only while idle.
// Path: a process item passes from the read stage register to the output register that drives mask.
// Throughput: one transaction per cycle while mask is not stalled, set by the
//  read-modify-write around the frame store (read at accept, write as the item
//  leaves the read stage); the item just behind a write to the same entry takes the written
//  word from a forwarding register.
// Reset: registers return to their defaults (threshold 30, weight 13, others
//  0). The frame store is not cleared; entries are undefined until written.
// Stall: a held mask transaction keeps its register; one more item may sit in
//  the read stage, then pixel.ready drops. Init items pass through regardless.
module running_average_background_subtract_top #(
	parameter int FRAME_PIXELS         = rabs_pkg::FRAME_PIXELS_DEF,
	parameter int WEIGHT_FRACTION_BITS = rabs_pkg::WEIGHT_FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rabs_pix_if.sink                         pixel,
	rabs_mask_if.source                      mask,
	input  logic                             cfg_we,
	input  logic [rabs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rabs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int XW    = rabs_pkg::XADDR_W;
	localparam int EW    = rabs_pkg::ENTRY_W;
	localparam int AW    = rabs_pkg::ADDR_W;
	localparam logic [XW-1:0] FRAME_LIMIT = XW'(FRAME_PIXELS);

	// config registers
	logic [rabs_pkg::THRESH_W-1:0] thr_q;
	logic [rabs_pkg::WEIGHT_W-1:0] weight_q;
	logic                          sel_q;
	logic                          col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= rabs_pkg::DIFF_THRESHOLD_RST;
			weight_q <= rabs_pkg::BLEND_WEIGHT_RST;
			sel_q    <= 1'b0;
			col_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rabs_pkg::CFG_DIFF_THRESHOLD: begin
					thr_q <= cfg_wdata[rabs_pkg::THRESH_W-1:0];
				end
				rabs_pkg::CFG_BLEND_WEIGHT: begin
					weight_q <= cfg_wdata[rabs_pkg::WEIGHT_W-1:0];
				end
				rabs_pkg::CFG_SELECTIVE_UPDATE: begin
					sel_q <= cfg_wdata[0];
				end
				rabs_pkg::CFG_COLOUR_MODE: begin
					col_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// accept stage: gray conversion, address range check, store read
	logic                          pix_acc;
	logic [rabs_pkg::GRAY_SUM_W-1:0] gray_sum;
	logic [rabs_pkg::CHAN_W-1:0]   gray;
	logic [XW-1:0]                 acc_xaddr;
	logic                          acc_inrange;
	logic [IDX_W-1:0]              acc_idx;
	logic [EW-1:0]                 acc_pix;

	assign gray_sum = rabs_pkg::GRAY_KR * rabs_pkg::GRAY_SUM_W'(pixel.red)
	                + rabs_pkg::GRAY_KG * rabs_pkg::GRAY_SUM_W'(pixel.green)
	                + rabs_pkg::GRAY_KB * rabs_pkg::GRAY_SUM_W'(pixel.blue)
	                + rabs_pkg::GRAY_HALF;
	assign gray        = gray_sum[rabs_pkg::GRAY_SHIFT +: rabs_pkg::CHAN_W];
	assign acc_xaddr   = XW'(pixel.pixel_address);
	assign acc_inrange = acc_xaddr < FRAME_LIMIT;
	assign acc_idx     = acc_xaddr[IDX_W-1:0];
	assign acc_pix     = col_q ? {pixel.red, pixel.green, pixel.blue} : EW'(gray);

	// read stage
	logic             valid_s1;
	rabs_pkg::req_t   req_s1;
	logic [AW-1:0]    addr_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inrange_s1;
	logic [EW-1:0]    pix_s1;
	logic             s1_adv;

	// output register
	logic          out_valid_q;
	logic          out_fg_q;
	logic [AW-1:0] out_addr_q;

	// an init item needs no output slot
	assign s1_adv = valid_s1 &&
	                (req_s1 == rabs_pkg::REQ_INIT || !out_valid_q || mask.ready);
	assign pixel.ready = !valid_s1 || s1_adv;
	assign pix_acc     = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			req_s1     <= rabs_pkg::req_t'(pixel.req_type);
			addr_s1    <= pixel.pixel_address;
			idx_s1     <= acc_idx;
			inrange_s1 <= acc_inrange;
			pix_s1     <= acc_pix;
		end
	end

	// frame store and forwarding of the last write
	logic             st_we;
	logic [EW-1:0]    st_wr_data;
	logic [EW-1:0]    st_rd_data;
	logic             wr_valid_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [EW-1:0]    wr_data_q;
	logic [EW-1:0]    bg_word;

	rabs_store #(
		.DEPTH (FRAME_PIXELS),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.rd_en   (pix_acc),
		.rd_idx  (acc_idx),
		.rd_data (st_rd_data),
		.wr_en   (st_we),
		.wr_idx  (idx_s1),
		.wr_data (st_wr_data)
	);

	// the write at the edge this item was read has not reached rd_data
	assign bg_word = (wr_valid_q && wr_idx_q == idx_s1) ? wr_data_q : st_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (st_we) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			wr_idx_q  <= idx_s1;
			wr_data_q <= st_wr_data;
		end
	end

	// compare and blend
	rabs_pkg::upd_ctrl_t upd_ctrl;
	logic                upd_fg;
	logic [EW-1:0]       upd_word;
	logic                s1_fg;

	assign upd_ctrl.colour    = col_q;
	assign upd_ctrl.threshold = thr_q;
	assign upd_ctrl.weight    = weight_q;

	rabs_update #(
		.WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
	) u_update (
		.ctrl     (upd_ctrl),
		.pix      (pix_s1),
		.bg       (bg_word),
		.fg       (upd_fg),
		.new_word (upd_word)
	);

	assign s1_fg = inrange_s1 && upd_fg;

	// selective mode keeps the background under foreground
	assign st_we = s1_adv && inrange_s1 &&
	               (req_s1 == rabs_pkg::REQ_INIT || !(sel_q && upd_fg));
	assign st_wr_data = (req_s1 == rabs_pkg::REQ_INIT) ? pix_s1 : upd_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && req_s1 == rabs_pkg::REQ_PROCESS) begin
			out_valid_q <= 1'b1;
		end else if (mask.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && req_s1 == rabs_pkg::REQ_PROCESS) begin
			out_fg_q   <= s1_fg;
			out_addr_q <= addr_s1;
		end
	end

	assign mask.valid       = out_valid_q;
	assign mask.foreground  = out_fg_q;
	assign mask.out_address = out_addr_q;

	logic st_wr_idx_eq;
	assign st_wr_idx_eq = idx_s1 == acc_idx;

`include "running_average_background_subtract_top_assert.svh"

	`RABS_ASSERT_NXT(a_fwd_hit, st_we && pix_acc && acc_inrange && st_wr_idx_eq,
		bg_word == $past(st_wr_data), "back-to-back hit did not see the fresh entry")
	`RABS_ASSERT_IMP(a_out_src, $rose(out_valid_q),
		$past(valid_s1 && req_s1 == rabs_pkg::REQ_PROCESS),
		"mask transaction without a process item")
	`RABS_ASSERT_NXT(a_stall_hold, out_valid_q && !mask.ready && valid_s1 &&
		req_s1 == rabs_pkg::REQ_PROCESS, valid_s1 && $stable(addr_s1),
		"process item left the read stage while the mask was stalled")
	`RABS_ASSERT_NXT(a_init_silent, s1_adv && req_s1 == rabs_pkg::REQ_INIT &&
		!out_valid_q, !out_valid_q, "init item produced a mask transaction")

endmodule

/* bench/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rabs_pkg::*;

	localparam int          SETTLE_CYCLES    = 4;
	localparam int          CYCLE_LIMIT      = 200000;  // many times the slowest clean run
	localparam int          RANDOM_SEGMENTS  = 6;
	localparam int          SEGMENT_ITEMS    = 90;
	localparam int          POOL_MAX         = 48;
	localparam int unsigned WEIGHT_ONE       = 1 << WEIGHT_FRACTION_BITS_DEF;

	// One pixel transaction as the sender sees it
	typedef struct {
		req_t              kind;
		logic [ADDR_W-1:0] addr;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} pixel_item_t;

	// One mask bit as the block should return it
	typedef struct {
		logic              fg;
		logic [ADDR_W-1:0] addr;
	} mask_bit_t;

	logic clk;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	rabs_pix_if  pix_ch();
	rabs_mask_if mask_ch();

	running_average_background_subtract_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_ch),
		.mask      (mask_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Pixels waiting for the driver, and mask bits waiting for the monitor
	pixel_item_t pixel_q[$];
	mask_bit_t   fg_expect_q[$];

	// Shadow of the frame store and of the register file, as the block should hold them
	logic [ENTRY_W-1:0]  bg_store [int unsigned];
	logic [THRESH_W-1:0] threshold_cfg;
	logic [WEIGHT_W-1:0] weight_cfg;
	logic                selective_cfg;
	logic                colour_cfg;

	// Stimulus bookkeeping: addresses already initialised and the last pixel sent to each
	logic [ADDR_W-1:0]  addr_pool[$];
	logic [ENTRY_W-1:0] last_pix [int unsigned];

	int          src_idle_pct;
	int          dst_idle_pct;
	int          fail_count;
	int          cycle_count;
	pixel_item_t cur_pixel;
	mask_bit_t   want;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// BT.601 luma; the three weights sum to one in Q0.14
	function automatic logic [CHAN_W-1:0] luma(input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		int unsigned acc;
		acc = GRAY_KR * r + GRAY_KG * g + GRAY_KB * b + GRAY_HALF;
		return CHAN_W'(acc >> GRAY_SHIFT);
	endfunction

	// Running average step: alpha above one acts as one, ties round up
	function automatic logic [CHAN_W-1:0] learn(input logic [CHAN_W-1:0] pix,
		input logic [CHAN_W-1:0] bg);
		int unsigned w;
		int unsigned acc;
		w   = (weight_cfg > WEIGHT_ONE) ? WEIGHT_ONE : weight_cfg;
		acc = w * pix + (WEIGHT_ONE - w) * bg + (WEIGHT_ONE >> 1);
		return CHAN_W'(acc >> WEIGHT_FRACTION_BITS_DEF);
	endfunction

	function automatic logic differs(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d > threshold_cfg;
	endfunction

	// Called once per accepted pixel, in acceptance order
	function automatic void subtract_and_learn(input pixel_item_t it);
		logic [ENTRY_W-1:0] entry;
		logic [CHAN_W-1:0]  gy;
		logic               fg;
		mask_bit_t          m;
		if (it.kind == REQ_INIT) begin
			bg_store[it.addr] = colour_cfg ? {it.r, it.g, it.b} : {16'h0, luma(it.r, it.g, it.b)};
			return;
		end
		entry = bg_store.exists(it.addr) ? bg_store[it.addr] : '0;
		if (colour_cfg) begin
			fg = differs(it.r, entry[23:16]) || differs(it.g, entry[15:8]) ||
				differs(it.b, entry[7:0]);
			if (!(selective_cfg && fg))
				bg_store[it.addr] = {learn(it.r, entry[23:16]), learn(it.g, entry[15:8]),
					learn(it.b, entry[7:0])};
		end else begin
			// gray mode looks at the low byte only, whatever mode wrote the entry
			gy = luma(it.r, it.g, it.b);
			fg = differs(gy, entry[7:0]);
			if (!(selective_cfg && fg))
				bg_store[it.addr] = {16'h0, learn(gy, entry[7:0])};
		end
		m.fg   = fg;
		m.addr = it.addr;
		fg_expect_q.push_back(m);
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset, cycle limit
	// ------------------------------------------------------------------

	initial begin
		// every block input known from time zero
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_DIFF_THRESHOLD;
		cfg_wdata            = '0;
		pix_ch.valid         = 1'b0;
		pix_ch.req_type      = REQ_INIT;
		pix_ch.pixel_address = '0;
		pix_ch.red           = '0;
		pix_ch.green         = '0;
		pix_ch.blue          = '0;
		mask_ch.ready        = 1'b0;
		clk                  = 1'b0;
		fork
			forever #5 clk = ~clk;
		join_none
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: one pixel transaction per handshake, random gaps on valid
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready)
				subtract_and_learn(cur_pixel);
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_pixel = pixel_q.pop_front();
					pix_ch.valid         <= 1'b1;
					pix_ch.req_type      <= cur_pixel.kind;
					pix_ch.pixel_address <= cur_pixel.addr;
					pix_ch.red           <= cur_pixel.r;
					pix_ch.green         <= cur_pixel.g;
					pix_ch.blue          <= cur_pixel.b;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each mask transaction against the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (mask_ch.valid && mask_ch.ready) begin
				if (fg_expect_q.size() == 0) begin
					$error("mask transaction with nothing expected: out_address %0h",
						mask_ch.out_address);
					fail_count++;
				end else begin
					want = fg_expect_q.pop_front();
					if (mask_ch.foreground !== want.fg) begin
						$error("foreground: expected %0b, got %0b (address %0h)",
							want.fg, mask_ch.foreground, want.addr);
						fail_count++;
					end
					if (mask_ch.out_address !== want.addr) begin
						$error("out_address: expected %0h, got %0h",
							want.addr, mask_ch.out_address);
						fail_count++;
					end
				end
			end
			mask_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_pixel(input req_t kind, input logic [ADDR_W-1:0] addr,
		input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		pixel_item_t it;
		it.kind = kind;
		it.addr = addr;
		it.r    = r;
		it.g    = g;
		it.b    = b;
		pixel_q.push_back(it);
		// only addresses written by an init may later be processed
		if (kind == REQ_INIT && !last_pix.exists(addr) && addr_pool.size() < POOL_MAX)
			addr_pool.push_back(addr);
		last_pix[addr] = {r, g, b};
	endtask

	// Wait until the block has swallowed everything and answered all of it
	task automatic settle();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || pix_ch.valid || fg_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back; only called while idle
	task automatic program_regs(input logic [THRESH_W-1:0] thr, input logic [WEIGHT_W-1:0] wt,
		input logic sel, input logic col);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DIFF_THRESHOLD;
		cfg_wdata <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= CFG_BLEND_WEIGHT;
		cfg_wdata <= wt;
		@(posedge clk);
		cfg_index <= CFG_SELECTIVE_UPDATE;
		cfg_wdata <= CFG_DATA_W'(sel);
		@(posedge clk);
		cfg_index <= CFG_COLOUR_MODE;
		cfg_wdata <= CFG_DATA_W'(col);
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold_cfg = thr;
		weight_cfg    = wt;
		selective_cfg = sel;
		colour_cfg    = col;
	endtask

	// Channel value near v, so that some pixels land close to their background
	function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(0, 80)) - 40;
		return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : CHAN_W'(t);
	endfunction

	// Mostly processing of known positions; some fresh inits as noise
	task automatic queue_random_pixel();
		int unsigned        roll;
		logic [ADDR_W-1:0]  a;
		logic [ENTRY_W-1:0] p;
		roll = $urandom_range(99);
		if (addr_pool.size() == 0 || roll < 12) begin
			a = ADDR_W'($urandom);
			push_pixel(REQ_INIT, a, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
		end else begin
			a = addr_pool[$urandom_range(addr_pool.size() - 1)];
			if (roll < 25) begin
				push_pixel(REQ_INIT, a, CHAN_W'($urandom), CHAN_W'($urandom),
					CHAN_W'($urandom));
			end else if (roll < 65) begin
				p = last_pix[a];
				push_pixel(REQ_PROCESS, a, nudge(p[23:16]), nudge(p[15:8]), nudge(p[7:0]));
			end else begin
				push_pixel(REQ_PROCESS, a, CHAN_W'($urandom), CHAN_W'($urandom),
					CHAN_W'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		logic [THRESH_W-1:0] thr;
		logic [WEIGHT_W-1:0] wt;
		fail_count    = 0;
		cycle_count   = 0;
		src_idle_pct  = 12;
		dst_idle_pct  = 86;
		threshold_cfg = DIFF_THRESHOLD_RST;
		weight_cfg    = BLEND_WEIGHT_RST;
		selective_cfg = 1'b0;
		colour_cfg    = 1'b0;
		@(posedge arst_n);

		// Reset defaults: gray, threshold 30, weight 13, update everywhere
		push_pixel(REQ_INIT,    19'h00000,   0,   0,   0);
		push_pixel(REQ_INIT,    19'h7FFFF, 255, 255, 255);
		push_pixel(REQ_INIT,    19'h00005, 100, 100, 100);
		push_pixel(REQ_PROCESS, 19'h00000, 255, 255, 255);
		push_pixel(REQ_PROCESS, 19'h7FFFF,   0,   0,   0);
		push_pixel(REQ_PROCESS, 19'h00005, 130, 130, 130);  // diff equals threshold
		push_pixel(REQ_PROCESS, 19'h00005, 133, 133, 133);  // one above threshold
		push_pixel(REQ_PROCESS, 19'h00000,   0,   0,   0);
		settle();

		// Colour mode over entries written in gray; zero threshold, alpha one, selective
		program_regs(8'd0, 9'd256, 1'b1, 1'b1);
		push_pixel(REQ_PROCESS, 19'h00005,   0,   0, 103);
		push_pixel(REQ_INIT,    19'h55555, 8'hAA, 8'h55, 8'h0F);
		push_pixel(REQ_PROCESS, 19'h55555, 8'hAA, 8'h55, 8'h0F);  // equal pixel
		push_pixel(REQ_PROCESS, 19'h55555, 8'hAA, 8'h56, 8'h0F);  // one channel off by one
		push_pixel(REQ_INIT,    19'h2AAAA,   1,   2,   3);
		settle();

		// Gray over colour entries; top threshold never fires, zero alpha freezes
		program_regs(8'd255, 9'd0, 1'b0, 1'b0);
		push_pixel(REQ_PROCESS, 19'h2AAAA, 255, 255, 255);
		push_pixel(REQ_PROCESS, 19'h55555,   0,   0,   0);
		push_pixel(REQ_PROCESS, 19'h7FFFF, 255,   0,   0);
		settle();

		// Oversized weight acts as one; selective keeps foreground background
		program_regs(8'd10, 9'd511, 1'b1, 1'b0);
		push_pixel(REQ_INIT,    19'h40000,   0, 255,   0);
		push_pixel(REQ_PROCESS, 19'h40000,   0, 250,   0);
		push_pixel(REQ_PROCESS, 19'h40000, 255,   0, 255);
		push_pixel(REQ_PROCESS, 19'h40000,   0, 255,   0);
		push_pixel(REQ_INIT,    19'h00001, 255,   0, 255);
		push_pixel(REQ_PROCESS, 19'h00001, 255,   0, 255);
		settle();

		// Random segments: fresh settings each, idle profile moves on every two
		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					src_idle_pct = 12;
					dst_idle_pct = 86;
				end
				1: begin
					src_idle_pct = 86;
					dst_idle_pct = 12;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			case ($urandom_range(3))
				0: thr = 8'd0;
				1: thr = 8'd255;
				default: thr = THRESH_W'($urandom_range(0, 80));
			endcase
			case ($urandom_range(4))
				0: wt = 9'd0;
				1: wt = 9'd256;
				2: wt = 9'd511;
				default: wt = WEIGHT_W'($urandom);
			endcase
			program_regs(thr, wt, 1'($urandom_range(1)), 1'($urandom_range(1)));
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				queue_random_pixel();
				// halfway: sender holds off until every mask bit is back
				if (n == SEGMENT_ITEMS / 2)
					settle();
			end
			settle();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/rabs_pkg.sv
hdl/rabs_if.sv
hdl/rabs_store.sv
hdl/rabs_update.sv
hdl/running_average_background_subtract_top.sv
bench/tb_top.sv
